FILE: rtl/pts_pkg.sv
// Package for the priority tick scheduler: sizes, opcodes and the structs
// that pass between the sequencer and the slot cells. No dependencies.
package pts_pkg;

  localparam int NumTasks  = 8;
  localparam int TaskIdxW  = 3;
  localparam int PrioW     = 8;
  localparam int SliceW    = 9;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } pts_op_e;

  // Broadcast command from the sequencer to every cell.
  typedef struct packed {
    logic                load;
    logic                dec;
    logic                clr_run;
    logic                refill;
    logic [TaskIdxW-1:0] idx;
    logic [PrioW-1:0]    prio;
    logic [SliceW-1:0]   slice;
    logic                present;
  } pts_cmd_t;

  // Best-candidate token that walks down the cell chain, one cell a cycle.
  typedef struct packed {
    logic                go;
    logic                found;
    logic [TaskIdxW-1:0] idx;
    logic [SliceW-1:0]   slice;
  } pts_tok_t;

endpackage

FILE: rtl/pts_if.sv
// Request and result channel interfaces for the priority tick scheduler.
// Depends on pts_pkg.
interface pts_req_if;
  import pts_pkg::*;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [TaskIdxW-1:0] slot_index;
  logic [PrioW-1:0]    slot_priority;
  logic [SliceW-1:0]   slot_counter;
  logic                slot_present;

  modport source (output valid, opcode, slot_index, slot_priority, slot_counter,
                  slot_present, input ready);
  modport sink   (input valid, opcode, slot_index, slot_priority, slot_counter,
                  slot_present, output ready);
endinterface

interface pts_rsp_if;
  import pts_pkg::*;
  logic                valid;
  logic                ready;
  logic [TaskIdxW-1:0] current_task;
  logic                switched;
  logic                refilled;
  logic                no_task;

  modport source (output valid, current_task, switched, refilled, no_task,
                  input ready);
  modport sink   (input valid, current_task, switched, refilled, no_task,
                  output ready);
endinterface

FILE: rtl/pts_cell.sv
// One task slot: holds priority, remaining slice and flags, and takes part
// in the chained best-slot search. Depends on pts_pkg.
module pts_cell
  import pts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [TaskIdxW-1:0] cell_id_i,
  input  pts_cmd_t            cmd_i,
  input  pts_tok_t            tok_i,
  output pts_tok_t            tok_o,
  output logic                present_o,
  output logic                zero_o
);

  logic [PrioW-1:0]  prio_q,  prio_d;
  logic [SliceW-1:0] slice_q, slice_d;
  logic              run_q,   run_d;
  logic              pres_q,  pres_d;
  pts_tok_t          tok_q,   tok_d;
  logic              sel;
  logic              take;

  assign sel = (cmd_i.idx == cell_id_i);

  always_comb begin
    prio_d  = prio_q;
    slice_d = slice_q;
    run_d   = run_q;
    pres_d  = pres_q;
    if (cmd_i.load && sel) begin
      prio_d  = cmd_i.prio;
      slice_d = cmd_i.slice;
      pres_d  = cmd_i.present;
    end else if (cmd_i.dec && sel && slice_q != '0) begin
      slice_d = slice_q - SliceW'(1);
    end else if (cmd_i.refill && pres_q) begin
      slice_d = {1'b0, prio_q} + SliceW'(1);
      run_d   = 1'b1;
    end
    if (cmd_i.clr_run && sel) begin
      run_d = 1'b0;
    end
  end

  // Later cells win ties: >= against the incoming best.
  assign take = pres_q && run_q && (slice_q != '0) &&
                (!tok_i.found || slice_q >= tok_i.slice);

  always_comb begin
    tok_d    = tok_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.idx   = cell_id_i;
      tok_d.slice = slice_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q  <= '0;
      slice_q <= '0;
      run_q   <= 1'b1;
      pres_q  <= 1'b0;
      tok_q   <= '0;
    end else begin
      prio_q  <= prio_d;
      slice_q <= slice_d;
      run_q   <= run_d;
      pres_q  <= pres_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o     = tok_q;
  assign present_o = pres_q;
  assign zero_o    = sel && (slice_q == '0);

endmodule

FILE: rtl/priority_tick_scheduler.sv
// Top level of the priority tick scheduler: sequencer, slot cell chain and
// result register. Depends on pts_pkg, pts_if and pts_cell.
//
//   channel  dir  modport            payload
//   req_i    in   pts_req_if.sink    opcode, slot_index, slot_priority,
//                                    slot_counter, slot_present
//   rsp_o    out  pts_rsp_if.source  current_task, switched, refilled, no_task
//
// A load goes straight to the result. A tick on a running task decrements its
// slice and checks it; a search follows only when that slice is zero. A
// search walks the token through the NUM_TASKS-1 cells, one per cycle; a tick
// from the idle task searches at once, and a refill forces a second search.
// Reset clears all slots at once; there is no clearing pass. A request is
// taken while the previous result still waits in the output register; the
// next result then holds the sequencer, and the request side, until it drains.
module priority_tick_scheduler
  import pts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  pts_req_if.sink   req_i,
  pts_rsp_if.source rsp_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DEC    = 7'b0000010,
    S_CHK    = 7'b0000100,
    S_LAUNCH = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_REFILL = 7'b0100000,
    S_DONE   = 7'b1000000
  } pts_state_e;

  pts_state_e          state_q, state_d;
  logic [TaskIdxW-1:0] cur_q, cur_d;
  logic [TaskIdxW-1:0] before_q, before_d;
  logic                refilled_q, refilled_d;
  logic                notask_q, notask_d;
  logic                pass_q, pass_d;

  logic                out_valid_q, out_valid_d;
  logic [TaskIdxW-1:0] out_task_q;
  logic                out_sw_q, out_ref_q, out_nt_q;
  logic                out_load;

  pts_cmd_t            cmd;
  pts_tok_t            tok [NumTasks];
  logic [NumTasks-1:1] present_vec;
  logic [NumTasks-1:1] zero_vec;
  logic                req_fire;
  logic                load_ok;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign load_ok     = (req_i.slot_index != '0) &&
                       (int'(req_i.slot_index) < NumTasks);

  always_comb begin
    cmd         = '0;
    cmd.idx     = cur_q;
    cmd.prio    = req_i.slot_priority;
    cmd.slice   = req_i.slot_counter;
    cmd.present = req_i.slot_present;
    case (state_q)
      S_IDLE: begin
        if (req_fire && req_i.opcode == OP_LOAD) begin
          cmd.load = load_ok;
          cmd.idx  = req_i.slot_index;
        end
      end
      S_DEC:    cmd.dec     = 1'b1;
      S_CHK:    cmd.clr_run = |zero_vec;
      S_REFILL: cmd.refill  = 1'b1;
      default: ;
    endcase
  end

  // Empty token enters the head of the chain.
  always_comb begin
    tok[0]    = '0;
    tok[0].go = (state_q == S_LAUNCH);
  end

  for (genvar i = 1; i < NumTasks; i++) begin : g_cell
    pts_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (TaskIdxW'(i)),
      .cmd_i     (cmd),
      .tok_i     (tok[i-1]),
      .tok_o     (tok[i]),
      .present_o (present_vec[i]),
      .zero_o    (zero_vec[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    before_d   = before_q;
    refilled_d = refilled_q;
    notask_d   = notask_q;
    pass_d     = pass_q;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          before_d   = cur_q;
          refilled_d = 1'b0;
          notask_d   = 1'b0;
          pass_d     = 1'b0;
          if (req_i.opcode == OP_LOAD) begin
            state_d = S_DONE;
          end else if (cur_q == '0) begin
            state_d = S_LAUNCH;
          end else begin
            state_d = S_DEC;
          end
        end
      end
      S_DEC: state_d = S_CHK;
      S_CHK: begin
        // slice ran out: runnable is cleared this cycle, search next
        state_d = (|zero_vec) ? S_LAUNCH : S_DONE;
      end
      S_LAUNCH: state_d = S_SCAN;
      S_SCAN: begin
        if (tok[NumTasks-1].go) begin
          if (tok[NumTasks-1].found) begin
            cur_d   = tok[NumTasks-1].idx;
            state_d = S_DONE;
          end else if (pass_q || !(|present_vec)) begin
            notask_d = 1'b1;
            state_d  = S_DONE;
          end else begin
            state_d = S_REFILL;
          end
        end
      end
      S_REFILL: begin
        refilled_d = 1'b1;
        pass_d     = 1'b1;
        state_d    = S_LAUNCH;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) out_valid_d = 1'b0;
    if (out_load)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      before_q    <= '0;
      refilled_q  <= 1'b0;
      notask_q    <= 1'b0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      before_q    <= before_d;
      refilled_q  <= refilled_d;
      notask_q    <= notask_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_task_q <= cur_q;
      out_sw_q   <= (cur_q != before_q);
      out_ref_q  <= refilled_q;
      out_nt_q   <= notask_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.current_task = out_task_q;
  assign rsp_o.switched     = out_sw_q;
  assign rsp_o.refilled     = out_ref_q;
  assign rsp_o.no_task      = out_nt_q;

  // Only the running task can have hit zero.
  a_one_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> $onehot0(zero_vec))
    else $error("more than one cell reports an empty slice");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[NumTasks-1].go |-> (state_q == S_SCAN))
    else $error("search token left the chain outside a search");

  a_refill_finds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && refilled_q |-> !notask_q)
    else $error("no task found after a refill");

  a_switch_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (cur_q != before_q) |-> (cur_q != '0) && !notask_q)
    else $error("switch to the idle task or with no task");

endmodule

FILE: test/priority_tick_scheduler_tb.sv
// Self-checking testbench for priority_tick_scheduler: random requests with
// idling on both sides, checked against a scoreboard that models the slots.
// Depends on pts_pkg, pts_if and the scheduler RTL.
module priority_tick_scheduler_tb;
  import pts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemCount  = 1800;
  localparam int CycleLimit = 1000000;
  localparam int TailCycles = 2 * NumTasks + 20;

  typedef struct packed {
    logic [TaskIdxW-1:0] cur_task;
    logic                switched;
    logic                refilled;
    logic                no_task;
  } sched_result_t;

  // Mirror of the slot table; one expected result per accepted request.
  class sched_scoreboard;
    logic [SliceW-1:0]   remaining [NumTasks];
    logic [PrioW-1:0]    prio_tab  [NumTasks];
    logic                runnable  [NumTasks];
    logic                present   [NumTasks];
    logic [TaskIdxW-1:0] running;
    sched_result_t       expected_q[$];
    int                  errors;

    function new();
      for (int i = 0; i < NumTasks; i++) begin
        remaining[i] = '0;
        prio_tab[i]  = '0;
        runnable[i]  = 1'b1;
        present[i]   = 1'b0;
      end
      running = '0;
      errors  = 0;
    endfunction

    // Largest nonzero slice among present, runnable slots; ties go high.
    function int pick_next();
      int best;
      best = -1;
      for (int i = 1; i < NumTasks; i++) begin
        if (present[i] && runnable[i] && remaining[i] != 0 &&
            (best < 0 || remaining[i] >= remaining[best]))
          best = i;
      end
      return best;
    endfunction

    function void run_schedule(output logic rf, output logic nt);
      int  nxt;
      bit  any;
      rf  = 1'b0;
      nt  = 1'b0;
      any = 1'b0;
      nxt = pick_next();
      if (nxt < 0) begin
        for (int i = 1; i < NumTasks; i++) begin
          if (present[i]) begin
            any          = 1'b1;
            runnable[i]  = 1'b1;
            remaining[i] = SliceW'(prio_tab[i]) + SliceW'(1);
          end
        end
        if (!any) begin
          nt = 1'b1;
          return;
        end
        rf  = 1'b1;
        nxt = pick_next();
        if (nxt < 0) begin
          nt = 1'b1;
          return;
        end
      end
      running = TaskIdxW'(nxt);
    endfunction

    function void note_request(pts_op_e op, logic [TaskIdxW-1:0] idx,
                               logic [PrioW-1:0] prio, logic [SliceW-1:0] cnt,
                               logic pres);
      sched_result_t       res;
      logic [TaskIdxW-1:0] prev;
      logic                rf, nt;
      prev = running;
      rf   = 1'b0;
      nt   = 1'b0;
      if (op == OP_LOAD) begin
        // slot 0 is the idle task and is never written
        if (idx != 0 && int'(idx) < NumTasks) begin
          prio_tab[idx]  = prio;
          remaining[idx] = cnt;
          present[idx]   = pres;
        end
      end else if (running == 0) begin
        run_schedule(rf, nt);
      end else begin
        if (remaining[running] != 0) remaining[running] = remaining[running] - 1'b1;
        if (remaining[running] == 0) begin
          runnable[running] = 1'b0;
          run_schedule(rf, nt);
        end
      end
      res.cur_task = running;
      res.switched = (running != prev);
      res.refilled = rf;
      res.no_task  = nt;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [TaskIdxW-1:0] cur, logic sw, logic rf, logic nt);
      sched_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: current_task %0d", cur);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (cur !== exp_r.cur_task) begin
        $error("current_task: expected %0d, got %0d", exp_r.cur_task, cur);
        errors++;
      end
      if (sw !== exp_r.switched) begin
        $error("switched: expected %0b, got %0b", exp_r.switched, sw);
        errors++;
      end
      if (rf !== exp_r.refilled) begin
        $error("refilled: expected %0b, got %0b", exp_r.refilled, rf);
        errors++;
      end
      if (nt !== exp_r.no_task) begin
        $error("no_task: expected %0b, got %0b", exp_r.no_task, nt);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   sent;
  bit   tx_calm;

  sched_scoreboard sb = new();

  pts_req_if req_if ();
  pts_rsp_if rsp_if ();

  priority_tick_scheduler u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("priority_tick_scheduler regression: fail");
      $finish;
    end
  end

  task automatic send_request(pts_op_e op, logic [TaskIdxW-1:0] idx,
                              logic [PrioW-1:0] prio, logic [SliceW-1:0] cnt,
                              logic pres);
    req_if.valid         <= 1'b1;
    req_if.opcode        <= op;
    req_if.slot_index    <= idx;
    req_if.slot_priority <= prio;
    req_if.slot_counter  <= cnt;
    req_if.slot_present  <= pres;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_request(op, idx, prio, cnt, pres);
    sent++;
  endtask

  task automatic tick();
    send_request(OP_TICK, TaskIdxW'($urandom), PrioW'($urandom), SliceW'($urandom),
                 1'($urandom));
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // valid is already low when nothing is pending
  task automatic wait_drained();
    if (sb.expected_q.size() != 0) begin
      req_if.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [SliceW-1:0] rand_slice();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return SliceW'($urandom_range(0, 6));
    if (r < 80) return SliceW'($urandom_range(0, 40));
    if (r < 95) return SliceW'($urandom);
    return '1;
  endfunction

  function automatic logic [PrioW-1:0] rand_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return PrioW'($urandom_range(0, 5));
    if (r < 90) return PrioW'($urandom);
    return '1;
  endfunction

  task automatic random_load();
    logic [TaskIdxW-1:0] idx;
    idx = ($urandom_range(0, 99) < 5) ? '0 : TaskIdxW'($urandom_range(1, NumTasks - 1));
    send_request(OP_LOAD, idx, rand_prio(), rand_slice(), $urandom_range(0, 99) < 85);
  endtask

  // request side
  initial begin : request_side
    int  n_loads, n_ticks;
    bit  paused;
    paused               = 1'b0;
    tx_calm              = 1'b0;
    sent                 = 0;
    cycles               = 0;
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.opcode        = OP_TICK;
    req_if.slot_index    = '0;
    req_if.slot_priority = '0;
    req_if.slot_counter  = '0;
    req_if.slot_present  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, idle slot writes, ties, refill, absent runner
    tick();                                          // nothing present
    send_request(OP_LOAD, '0, '1, '1, 1'b1);         // slot 0 write ignored
    tick();
    send_request(OP_LOAD, 3'd7, '1, '1, 1'b1);
    send_request(OP_LOAD, 3'd1, '0, '0, 1'b1);       // present, empty slice
    send_request(OP_LOAD, 3'd3, 8'd2, '1, 1'b1);     // ties with slot 7
    tick();                                          // picks 7
    tick();
    send_request(OP_LOAD, 3'd7, '1, 9'd1, 1'b1);
    tick();                                          // 7 runs out, picks 3
    send_request(OP_LOAD, 3'd3, 8'd2, '0, 1'b0);
    tick();                                          // refill from priorities
    send_request(OP_LOAD, 3'd7, '1, 9'd2, 1'b0);
    send_request(OP_LOAD, 3'd1, '0, '0, 1'b0);
    tick();                                          // runner absent, still counts
    tick();                                          // nobody present
    send_request(OP_LOAD, 3'd5, '1, '0, 1'b1);
    tick();
    send_request(OP_LOAD, 3'd2, '0, 9'd1, 1'b1);
    send_request(OP_LOAD, 3'd6, 8'h55, 9'h0AA, 1'b1);
    send_request(OP_LOAD, 3'd4, 8'hAA, 9'h155, 1'b1);
    tick();
    tick();
    wait_drained();

    while (sent < ItemCount) begin
      if (!paused && sent >= ItemCount / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
      n_loads = $urandom_range(0, 3);
      n_ticks = $urandom_range(1, 10);
      repeat (n_loads) begin
        random_load();
        idle_cycles(pick_gap());
      end
      repeat (n_ticks) begin
        tick();
        idle_cycles(pick_gap());
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("priority_tick_scheduler regression: pass");
    end else begin
      $display("priority_tick_scheduler regression: fail");
    end
    $finish;
  end

  // result side: random back-pressure, calm stretches, one long hold-off
  initial begin : result_side
    int   stall_left, results, r;
    bit   rx_calm, held;
    logic nxt;
    stall_left   = 0;
    results      = 0;
    rx_calm      = 1'b0;
    held         = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        sb.check_result(rsp_if.current_task, rsp_if.switched, rsp_if.refilled,
                        rsp_if.no_task);
        results++;
      end
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (!held && results >= 300) begin
        held       = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (rx_calm) begin
        nxt = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          nxt = 1'b1;
        end else begin
          nxt        = 1'b0;
          stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(15, 50);
        end
      end
      rsp_if.ready <= nxt;
    end
  end

endmodule
